// ===== hw/rtl/dhp_pkg.sv =====
package dhp_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ZERO  = 3'd1,
    PH_DEC   = 3'd2,
    PH_HEX   = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  // classified character word passed from front to back
  typedef struct packed {
    logic       is_nul;
    logic       is_dec;
    logic       is_x;
    logic       is_hex;
    logic [3:0] digit;
  } tok_t;

endpackage

// ===== hw/rtl/decimal_hex_number_parser_top.sv =====
// Streaming decimal/hex number parser, one character word per cycle while in_stall is low.
// Throughput: one character per cycle unless the queue is full, limited by the combinational
// x10/x16 accumulate in the back end; a 4-word queue decouples input from result stalls.
// The NUL word passes through the queue; the result is loaded into the output register
// when that word leaves the queue, later if earlier words still wait in the queue or the
// previous result is still held by out_stall.
// Reset (rst, synchronous): queue empty, parser at start of string, no result.
module decimal_hex_number_parser_top import dhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [31:0] value,
  output logic [15:0] end_index,
  output logic        out_valid,
  input  logic        out_stall
);

  logic push;
  tok_t push_tok;
  logic q_full;
  logic pop;
  logic head_valid;
  tok_t head_tok;

  dhp_front u_front (
    .ch       (ch),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .push     (push),
    .push_tok (push_tok),
    .q_full   (q_full)
  );

  dhp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_tok   (push_tok),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  dhp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop),
    .value      (value),
    .end_index  (end_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

// ===== hw/rtl/dhp_front.sv =====
module dhp_front import dhp_pkg::*; (
  input  logic [7:0] ch,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       push,
  output tok_t       push_tok,
  input  logic       q_full
);

  logic is_dec;
  logic is_alpha_hex;

  always_comb begin
    is_dec       = ch inside {[8'h30:8'h39]};
    is_alpha_hex = ch inside {[8'h41:8'h46], [8'h61:8'h66]};
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_tok.is_nul = (ch == 8'h00);
    push_tok.is_dec = is_dec;
    push_tok.is_x   = (ch == 8'h78) || (ch == 8'h58);
    push_tok.is_hex = is_dec || is_alpha_hex;
    // letters A-F/a-f have low nibble 1..6, so +9 gives 10..15
    push_tok.digit  = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);
  end

endmodule

// ===== hw/rtl/dhp_queue.sv =====
module dhp_queue import dhp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output tok_t head_tok
);

  tok_t            mem [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    count;

  assign full       = (count == (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dhp_back.sv =====
module dhp_back import dhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  tok_t        head_tok,
  output logic        pop,
  output logic [31:0] value,
  output logic [15:0] end_index,
  output logic        out_valid,
  input  logic        out_stall
);

  phase_t      phase, phase_next;
  logic [31:0] acc, acc_next;
  logic [15:0] position, position_next;
  logic [15:0] stop_index, stop_index_next;
  logic        out_valid_next;
  logic        load_out;
  logic [15:0] endi;
  logic [31:0] acc_dec;
  logic [31:0] acc_hex;

  // x10 = x8 + x2
  assign acc_dec = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, head_tok.digit};
  assign acc_hex = {acc[27:0], head_tok.digit};

  // a NUL word needs the output register free
  assign pop      = head_valid && (!head_tok.is_nul || !out_valid || !out_stall);
  assign load_out = pop && head_tok.is_nul;

  always_comb begin
    case (phase)
      PH_START:                endi = '0;
      PH_ZERO, PH_DEC, PH_HEX: endi = position;
      default:                 endi = stop_index;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    position_next   = position;
    stop_index_next = stop_index;
    if (pop) begin
      if (head_tok.is_nul) begin
        phase_next      = PH_START;
        acc_next        = '0;
        position_next   = '0;
        stop_index_next = '0;
      end else begin
        case (phase)
          PH_START: begin
            if (head_tok.is_dec) begin
              acc_next   = {28'd0, head_tok.digit};
              phase_next = (head_tok.digit == 4'd0) ? PH_ZERO : PH_DEC;
            end else begin
              acc_next        = '0;
              stop_index_next = '0;
              phase_next      = PH_DONE;
            end
          end
          PH_ZERO: begin
            if (head_tok.is_x) begin
              acc_next   = '0;
              phase_next = PH_HEX;
            end else if (head_tok.is_dec) begin
              acc_next   = acc_dec;
              phase_next = PH_DEC;
            end else begin
              stop_index_next = position;
              phase_next      = PH_DONE;
            end
          end
          PH_DEC: begin
            if (head_tok.is_dec) begin
              acc_next = acc_dec;
            end else begin
              stop_index_next = position;
              phase_next      = PH_DONE;
            end
          end
          PH_HEX: begin
            if (head_tok.is_hex) begin
              acc_next = acc_hex;
            end else begin
              stop_index_next = position;
              phase_next      = PH_DONE;
            end
          end
          default: ;
        endcase
        if (position != POS_MAX) position_next = position + 16'd1;
      end
    end
  end

  always_comb begin
    if (load_out)        out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
    else                 out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      acc        <= '0;
      position   <= '0;
      stop_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      acc        <= acc_next;
      position   <= position_next;
      stop_index <= stop_index_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value     <= acc;
      end_index <= endi;
    end
  end

endmodule
